FILE: design/ofcc_pkg.sv
package ofcc_pkg;

   localparam int WHEEL_SIZE   = 55;
   localparam int WHEEL_AW     = 6;
   localparam int HUE_W        = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_SCALE = 24;
   localparam int RN_W         = 16;
   localparam int RN_FRAC      = 14;
   localparam int SQ_SHIFT     = 2 * RN_FRAC;
   localparam int MIX_W        = 24;
   localparam int PROD_W       = 40;
   localparam int CFG_W        = 16;
   localparam int CHAN_W       = 8;

   typedef logic [HUE_W-1:0]  hue_type;
   typedef logic [MIX_W-1:0]  mix_type;
   typedef logic [CHAN_W-1:0] chan_type;

   localparam logic [CFG_W-1:0]  CFG_MAX_RADIUS_RESET = 16'd2560;
   localparam logic [RN_W-1:0]   RN_ONE     = 16'd16384;
   localparam logic [RN_W-1:0]   RN_SAT     = 16'd32768;
   localparam hue_type           HUE_ZERO   = 16'h0000;
   localparam hue_type           HUE_QUART  = 16'h4000;
   localparam hue_type           HUE_HALF   = 16'h8000;
   localparam hue_type           HUE_3QUART = 16'hC000;
   localparam logic [16:0]       FRAC_ONE   = 17'd65536;
   localparam logic [5:0]        HUE_SPAN   = 6'd54;
   localparam mix_type           MIX_FULL   = 24'd16711680;
   localparam logic [PROD_W-1:0] OUT_FULL   = 40'd273804165120;

   localparam hue_type ATAN_TURNS [CORDIC_STEPS] = '{
      16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
      16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0
   };

   localparam chan_type WHEEL_R [WHEEL_SIZE] = '{
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd213, 8'd170, 8'd128, 8'd85, 8'd43,
      8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd19, 8'd39, 8'd58, 8'd78, 8'd98, 8'd117, 8'd137, 8'd156,
      8'd176, 8'd196, 8'd215, 8'd235,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

   localparam chan_type WHEEL_G [WHEEL_SIZE] = '{
      8'd0, 8'd17, 8'd34, 8'd51, 8'd68, 8'd85, 8'd102, 8'd119,
      8'd136, 8'd153, 8'd170, 8'd187, 8'd204, 8'd221, 8'd238,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd232, 8'd209, 8'd186, 8'd163, 8'd140, 8'd116, 8'd93,
      8'd70, 8'd47, 8'd24,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };

   localparam chan_type WHEEL_B [WHEEL_SIZE] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd63, 8'd127, 8'd191,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd213, 8'd170, 8'd128, 8'd85, 8'd43
   };

endpackage

FILE: design/ofcc_sqrt_cell.sv
module ofcc_sqrt_cell #(
   parameter int NB = 60,
   parameter int RW = 30
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NB-1:0] up_n,
   input  logic [RW+1:0] up_rem,
   input  logic [RW-1:0] up_root,
   output logic [NB-1:0] dn_n,
   output logic [RW+1:0] dn_rem,
   output logic [RW-1:0] dn_root
);
   logic [NB-1:0] n_ff, n_in;
   logic [RW+1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW+1:0] rem_sh;
   logic [RW+1:0] trial;
   logic          ge;

   // bring down two radicand bits and try the next root bit
   always_comb begin
      rem_sh  = {up_rem[RW-1:0], up_n[NB-1:NB-2]};
      trial   = {up_root, 2'b01};
      ge      = (rem_sh >= trial);
      rem_in  = ge ? (rem_sh - trial) : rem_sh;
      root_in = {up_root[RW-2:0], ge};
      n_in    = {up_n[NB-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= n_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dn_n    = n_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
endmodule

FILE: design/ofcc_div_cell.sv
module ofcc_div_cell #(
   parameter int DW = 47
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [DW-1:0]         up_rem,
   input  logic [DW-1:0]         up_div,
   input  logic [ofcc_pkg::RN_W-1:0] up_quo,
   output logic [DW-1:0]         dn_rem,
   output logic [DW-1:0]         dn_div,
   output logic [ofcc_pkg::RN_W-1:0] dn_quo
);
   import ofcc_pkg::*;

   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   div_ff, div_in;
   logic [RN_W-1:0] quo_ff, quo_in;
   logic            ge;

   always_comb begin
      ge     = (up_rem >= up_div);
      rem_in = ge ? (up_rem - up_div) : up_rem;
      quo_in = {up_quo[RN_W-2:0], ge};
      div_in = up_div >> 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         div_ff <= div_in;
         quo_ff <= quo_in;
      end
   end

   assign dn_rem = rem_ff;
   assign dn_div = div_ff;
   assign dn_quo = quo_ff;
endmodule

FILE: design/ofcc_cordic_cell.sv
module ofcc_cordic_cell #(
   parameter int CW   = 43,
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [CW-1:0]  up_x,
   input  logic signed [CW-1:0]  up_y,
   input  ofcc_pkg::hue_type     up_acc,
   output logic signed [CW-1:0]  dn_x,
   output logic signed [CW-1:0]  dn_y,
   output ofcc_pkg::hue_type     dn_acc
);
   import ofcc_pkg::*;

   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   hue_type              acc_ff, acc_in;

   // rotate towards the x axis
   always_comb begin
      if (up_y > 0) begin
         x_in   = up_x + (up_y >>> STEP);
         y_in   = up_y - (up_x >>> STEP);
         acc_in = up_acc + ATAN_TURNS[STEP];
      end else begin
         x_in   = up_x - (up_y >>> STEP);
         y_in   = up_y + (up_x >>> STEP);
         acc_in = up_acc - ATAN_TURNS[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
      end
   end

   assign dn_x   = x_ff;
   assign dn_y   = y_ff;
   assign dn_acc = acc_ff;
endmodule

FILE: design/optical_flow_color_coding_core.sv
// Channel   Ports                                        Direction
// req       req_valid, req_stall, req_flow_x/_y/_valid   flow vector in
// rsp       rsp_valid, rsp_stall, rsp_red/_green/_blue   colour out
// csr       csr_wr_en, csr_wr_data                       max_radius write
//
// One transaction per clock while req_stall is low; results pass through the
// square-root chain (one root bit per cell, FLOW_WIDTH+14 cells) and the
// 16-cell divider behind it. Synchronous reset clears the valid line and
// sets max_radius to 2560. rsp_stall freezes the whole pipe only when its last
// stage holds a result that cannot move; a bubble there lets the pipe drain.
module optical_flow_color_coding_core #(
   parameter int FLOW_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [FLOW_WIDTH-1:0]    req_flow_x,
   input  logic signed [FLOW_WIDTH-1:0]    req_flow_y,
   input  logic                            req_flow_valid,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ofcc_pkg::chan_type              rsp_red,
   output ofcc_pkg::chan_type              rsp_green,
   output ofcc_pkg::chan_type              rsp_blue,
   input  logic                            csr_wr_en,
   input  logic [ofcc_pkg::CFG_W-1:0]      csr_wr_data
);
   import ofcc_pkg::*;

   localparam int SQ_W  = 2 * FLOW_WIDTH;
   localparam int NB    = SQ_W + SQ_SHIFT;
   localparam int RW    = FLOW_WIDTH + RN_FRAC;
   localparam int DW    = RW + 17;
   localparam int CW    = FLOW_WIDTH + CORDIC_SCALE + 3;
   localparam int CMP_W = SQ_W + 34;
   localparam int PL    = RW + 19;
   localparam int CD    = RW - 2;
   localparam int SATD  = RW + 16;

   // ---------------- configuration
   logic [CFG_W-1:0]   mrad_ff, mrad_in;
   logic [CFG_W-1:0]   m_eff;
   logic [2*CFG_W-1:0] msq_ff, msq_in;

   always_comb begin
      mrad_in = csr_wr_en ? csr_wr_data : mrad_ff;
      m_eff   = (mrad_ff == '0) ? CFG_W'(1) : mrad_ff;
      msq_in  = m_eff * m_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mrad_ff <= CFG_MAX_RADIUS_RESET;
      end else begin
         mrad_ff <= mrad_in;
      end
      msq_ff <= msq_in;
   end

   // ---------------- flow control
   logic        en;
   logic        accept;
   logic        vld_ff [1:PL];
   logic        fv_ff  [1:PL];
   logic        rsp_valid_ff;
   logic        rsp_load;

   assign en        = !(vld_ff[PL] && rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 1; j <= PL; j++) vld_ff[j] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= accept;
         for (int j = 2; j <= PL; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fv_ff[1] <= req_flow_valid;
         for (int j = 2; j <= PL; j++) fv_ff[j] <= fv_ff[j-1];
      end
   end

   // ---------------- radius: squares and sum
   logic signed [FLOW_WIDTH:0] xe, ye, xn, yn;
   logic [FLOW_WIDTH-1:0]      ax, ay;
   logic [SQ_W-1:0]            sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SQ_W-1:0]            s_ff, s_in;
   logic                       sat_ff [0:SATD];
   logic                       sat_in;

   always_comb begin
      xe     = (FLOW_WIDTH+1)'(req_flow_x);
      ye     = (FLOW_WIDTH+1)'(req_flow_y);
      xn     = -xe;
      yn     = -ye;
      ax     = xe[FLOW_WIDTH] ? xn[FLOW_WIDTH-1:0] : xe[FLOW_WIDTH-1:0];
      ay     = ye[FLOW_WIDTH] ? yn[FLOW_WIDTH-1:0] : ye[FLOW_WIDTH-1:0];
      sqx_in = ax * ax;
      sqy_in = ay * ay;
      s_in   = sqx_ff + sqy_ff;
      sat_in = (CMP_W'(s_in) >= CMP_W'({msq_ff, 2'b00}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
         s_ff      <= s_in;
         sat_ff[0] <= sat_in;
         for (int j = 1; j <= SATD; j++) sat_ff[j] <= sat_ff[j-1];
      end
   end

   // ---------------- radius: square-root chain
   logic [NB-1:0] sq_n    [RW+1];
   logic [RW+1:0] sq_rem  [RW+1];
   logic [RW-1:0] sq_root [RW+1];

   assign sq_n[0]    = {s_ff, {SQ_SHIFT{1'b0}}};
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar g = 0; g < RW; g++) begin : g_sqrt
      ofcc_sqrt_cell #(.NB(NB), .RW(RW)) u_cell (
         .clock   (clock),
         .en      (en),
         .up_n    (sq_n[g]),
         .up_rem  (sq_rem[g]),
         .up_root (sq_root[g]),
         .dn_n    (sq_n[g+1]),
         .dn_rem  (sq_rem[g+1]),
         .dn_root (sq_root[g+1])
      );
   end

   // ---------------- radius: divide by max_radius
   logic [DW-1:0]   dv_rem [RN_W+1];
   logic [DW-1:0]   dv_div [RN_W+1];
   logic [RN_W-1:0] dv_quo [RN_W+1];

   assign dv_rem[0] = DW'(sq_root[RW]);
   assign dv_div[0] = DW'(m_eff) << (RN_W - 1);
   assign dv_quo[0] = '0;

   for (genvar g = 0; g < RN_W; g++) begin : g_div
      ofcc_div_cell #(.DW(DW)) u_cell (
         .clock  (clock),
         .en     (en),
         .up_rem (dv_rem[g]),
         .up_div (dv_div[g]),
         .up_quo (dv_quo[g]),
         .dn_rem (dv_rem[g+1]),
         .dn_div (dv_div[g+1]),
         .dn_quo (dv_quo[g+1])
      );
   end

   // ---------------- hue: CORDIC set-up
   logic signed [CW-1:0] xs, ys;
   logic signed [CW-1:0] cx   [CORDIC_STEPS+1];
   logic signed [CW-1:0] cy   [CORDIC_STEPS+1];
   hue_type              cacc [CORDIC_STEPS+1];
   logic signed [CW-1:0] cx0_ff, cx0_in, cy0_ff, cy0_in;
   hue_type              cacc0_ff, cacc0_in;
   logic                 spec_ff [0:CORDIC_STEPS];
   hue_type              spech_ff [0:CORDIC_STEPS];
   logic                 spec_in;
   hue_type              spech_in;

   always_comb begin
      xs = CW'(xe) <<< CORDIC_SCALE;
      ys = CW'(ye) <<< CORDIC_SCALE;
      spec_in  = 1'b1;
      spech_in = HUE_ZERO;
      priority if (req_flow_y == '0) begin
         spech_in = xe[FLOW_WIDTH] ? HUE_HALF : HUE_ZERO;
      end else if (req_flow_x == '0) begin
         spech_in = ye[FLOW_WIDTH] ? HUE_3QUART : HUE_QUART;
      end else begin
         spec_in = 1'b0;
      end
      if (xe[FLOW_WIDTH]) begin
         cx0_in   = -xs;
         cy0_in   = -ys;
         cacc0_in = HUE_HALF;
      end else begin
         cx0_in   = xs;
         cy0_in   = ys;
         cacc0_in = HUE_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx0_ff      <= cx0_in;
         cy0_ff      <= cy0_in;
         cacc0_ff    <= cacc0_in;
         spec_ff[0]  <= spec_in;
         spech_ff[0] <= spech_in;
         for (int j = 1; j <= CORDIC_STEPS; j++) begin
            spec_ff[j]  <= spec_ff[j-1];
            spech_ff[j] <= spech_ff[j-1];
         end
      end
   end

   assign cx[0]   = cx0_ff;
   assign cy[0]   = cy0_ff;
   assign cacc[0] = cacc0_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      ofcc_cordic_cell #(.CW(CW), .STEP(g)) u_cell (
         .clock  (clock),
         .en     (en),
         .up_x   (cx[g]),
         .up_y   (cy[g]),
         .up_acc (cacc[g]),
         .dn_x   (cx[g+1]),
         .dn_y   (cy[g+1]),
         .dn_acc (cacc[g+1])
      );
   end

   // ---------------- hue: wheel position and blend
   hue_type             hue;
   logic [HUE_W+5:0]    t_full;
   logic [WHEEL_AW-1:0] k0_ff, k0_in, k1;
   logic [HUE_W-1:0]    f_ff, f_in, fw_ff;
   chan_type            w0_ff [3];
   chan_type            w1_ff [3];
   chan_type            w0_in [3];
   chan_type            w1_in [3];
   mix_type             mix_ff [0:CD][3];
   mix_type             mix_in [3];
   logic [16:0]         fc;

   always_comb begin
      hue    = spec_ff[CORDIC_STEPS] ? spech_ff[CORDIC_STEPS] : cacc[CORDIC_STEPS];
      t_full = hue * HUE_SPAN;
      k0_in  = t_full[HUE_W+5:HUE_W];
      f_in   = t_full[HUE_W-1:0];
      k1     = (k0_ff == WHEEL_AW'(WHEEL_SIZE - 1)) ? '0 : k0_ff + 1'b1;
      w0_in[0] = WHEEL_R[k0_ff];
      w0_in[1] = WHEEL_G[k0_ff];
      w0_in[2] = WHEEL_B[k0_ff];
      w1_in[0] = WHEEL_R[k1];
      w1_in[1] = WHEEL_G[k1];
      w1_in[2] = WHEEL_B[k1];
      fc = FRAC_ONE - 17'(fw_ff);
      for (int c = 0; c < 3; c++) begin
         mix_in[c] = MIX_W'(25'(fc * w0_ff[c]) + 25'(fw_ff * w1_ff[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k0_ff <= k0_in;
         f_ff  <= f_in;
         fw_ff <= f_ff;
         for (int c = 0; c < 3; c++) begin
            w0_ff[c]     <= w0_in[c];
            w1_ff[c]     <= w1_in[c];
            mix_ff[0][c] <= mix_in[c];
         end
         // hold the blend until the radius catches up
         for (int j = 1; j <= CD; j++) begin
            for (int c = 0; c < 3; c++) mix_ff[j][c] <= mix_ff[j-1][c];
         end
      end
   end

   // ---------------- shade
   logic [RN_W-1:0]   rn;
   logic [PROD_W-1:0] prod_ff [3];
   logic [PROD_W-1:0] prod_in [3];
   logic [6:0]        half_ff [3];
   logic              low_ff, low_in;

   always_comb begin
      priority if (sat_ff[SATD]) begin
         rn = RN_SAT;
      end else if (dv_quo[RN_W] > RN_SAT) begin
         rn = RN_SAT;
      end else begin
         rn = dv_quo[RN_W];
      end
      low_in = (rn <= RN_ONE);
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = rn * (MIX_FULL - mix_ff[CD][c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         low_ff <= low_in;
         for (int c = 0; c < 3; c++) begin
            prod_ff[c] <= prod_in[c];
            half_ff[c] <= mix_ff[CD][c][MIX_W-1:17];
         end
      end
   end

   // ---------------- output register
   chan_type          col_ff [3];
   chan_type          col_in [3];
   logic [PROD_W-1:0] lit;

   always_comb begin
      lit = '0;
      for (int c = 0; c < 3; c++) begin
         lit = OUT_FULL - prod_ff[c];
         if (!fv_ff[PL]) begin
            col_in[c] = '0;
         end else if (low_ff) begin
            col_in[c] = lit[37:30];
         end else begin
            col_in[c] = {1'b0, half_ff[c]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= vld_ff[PL];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && vld_ff[PL]) begin
         for (int c = 0; c < 3; c++) col_ff[c] <= col_in[c];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = col_ff[0];
   assign rsp_green = col_ff[1];
   assign rsp_blue  = col_ff[2];
endmodule

FILE: bench/tb_optical_flow_color_coding_core.sv
`timescale 1ns / 1ps

module tb_optical_flow_color_coding_core;
   import ofcc_pkg::*;

   localparam int FW        = 16;
   localparam int LATENCY   = FW + 34;
   localparam int CYCLE_CAP = 400000;

   typedef struct {
      logic signed [FW-1:0] x;
      logic signed [FW-1:0] y;
      logic                 ok;
   } flow_vec_type;

   typedef struct {
      chan_type r;
      chan_type g;
      chan_type b;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [FW-1:0] req_flow_x = '0;
   logic signed [FW-1:0] req_flow_y = '0;
   logic req_flow_valid = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   chan_type rsp_red, rsp_green, rsp_blue;
   logic csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   flow_vec_type vec_queue[$];
   pixel_type    pixel_queue[$];
   logic [CFG_W-1:0] radius_cfg = CFG_MAX_RADIUS_RESET;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int errors = 0;
   int n_pixels = 0;
   int n_vectors = 0;
   int hold_left = 0;
   bit hold_done = 0;
   longint cycles = 0;

   optical_flow_color_coding_core #(.FLOW_WIDTH(FW)) u_top (.*);

   always #10 clock = ~clock;

   function automatic longint unsigned root_of(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic hue_type hue_of(longint x, longint y);
      longint vx, vy, nx, ny;
      int unsigned acc;
      vx = -x;
      vy = -y;
      acc = 32768;
      if (vy == 0) return (vx > 0) ? HUE_HALF : HUE_ZERO;
      if (vx == 0) return (vy > 0) ? HUE_3QUART : HUE_QUART;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         acc += 32768;
      end
      vx = vx <<< CORDIC_SCALE;
      vy = vy <<< CORDIC_SCALE;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (vy > 0) begin
            nx = vx + (vy >>> i);
            ny = vy - (vx >>> i);
            acc += ATAN_TURNS[i];
         end else begin
            nx = vx - (vy >>> i);
            ny = vy + (vx >>> i);
            acc -= ATAN_TURNS[i];
         end
         vx = nx;
         vy = ny;
      end
      return acc[15:0];
   endfunction

   // segment lengths 15, 6, 4, 11, 13, 6 around the wheel
   function automatic void wheel_rgb(int k, output int rgb[3]);
      if (k < 15) begin rgb = '{255, 255 * k / 15, 0}; return; end
      k -= 15;
      if (k < 6) begin rgb = '{255 - 255 * k / 6, 255, 0}; return; end
      k -= 6;
      if (k < 4) begin rgb = '{0, 255, 255 * k / 4}; return; end
      k -= 4;
      if (k < 11) begin rgb = '{0, 255 - 255 * k / 11, 255}; return; end
      k -= 11;
      if (k < 13) begin rgb = '{255 * k / 13, 0, 255}; return; end
      k -= 13;
      if (k >= 6) k = 5;
      rgb = '{255, 0, 255 - 255 * k / 6};
   endfunction

   function automatic pixel_type flow_colour(flow_vec_type v, logic [CFG_W-1:0] radius);
      longint x, y;
      longint unsigned ax, ay, s, m, rn, t, f, c, o;
      int k0, k1;
      int w0[3], w1[3];
      longint unsigned chans[3];
      pixel_type p;
      if (!v.ok) begin
         p = '{8'd0, 8'd0, 8'd0};
         return p;
      end
      x = v.x;
      y = v.y;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      s = ax * ax + ay * ay;
      m = (radius == 0) ? 1 : radius;
      if (s >= 4 * m * m) rn = 32768;
      else begin
         rn = root_of(s << 28) / m;
         if (rn > 32768) rn = 32768;
      end
      t = longint'(hue_of(x, y)) * (WHEEL_SIZE - 1);
      k0 = int'(t >> 16);
      f = t & 64'hFFFF;
      k1 = (k0 + 1) % WHEEL_SIZE;
      wheel_rgb(k0, w0);
      wheel_rgb(k1, w1);
      for (int ch = 0; ch < 3; ch++) begin
         c = (65536 - f) * w0[ch] + f * w1[ch];
         if (rn <= 16384) o = ((64'd255 << 30) - rn * (255 * 65536 - c)) >> 30;
         else o = c >> 17;
         chans[ch] = o & 64'hFF;
      end
      p.r = chans[0][7:0];
      p.g = chans[1][7:0];
      p.b = chans[2][7:0];
      return p;
   endfunction

   // driver: predict on each accepted transaction, then offer the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pixel_queue.push_back(flow_colour('{req_flow_x, req_flow_y, req_flow_valid},
                                              radius_cfg));
            n_vectors++;
         end
         if (!req_valid || !req_stall) begin
            if (vec_queue.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
               flow_vec_type v;
               v = vec_queue.pop_front();
               req_flow_x <= v.x;
               req_flow_y <= v.y;
               req_flow_valid <= v.ok;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check accepted transactions, randomise stall, one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               $error("unexpected colour r=%0d g=%0d b=%0d", rsp_red, rsp_green, rsp_blue);
               errors++;
            end else begin
               pixel_type e;
               e = pixel_queue.pop_front();
               if (rsp_red !== e.r) begin
                  $error("red: expected %0d, got %0d", e.r, rsp_red);
                  errors++;
               end
               if (rsp_green !== e.g) begin
                  $error("green: expected %0d, got %0d", e.g, rsp_green);
                  errors++;
               end
               if (rsp_blue !== e.b) begin
                  $error("blue: expected %0d, got %0d", e.b, rsp_blue);
                  errors++;
               end
            end
            n_pixels++;
         end
         if (!hold_done && n_pixels >= 1200) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_radius(logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      radius_cfg = value;
   endtask

   task automatic add_vec(int x, int y, bit ok);
      flow_vec_type v;
      v.x = x[FW-1:0];
      v.y = y[FW-1:0];
      v.ok = ok;
      vec_queue.push_back(v);
   endtask

   task automatic add_random(int count);
      int sel, lim;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(9);
         lim = 2 * radius_cfg + 1;
         if (lim > 32767) lim = 32767;
         case (sel)
            0: add_vec($urandom, $urandom, 1'($urandom));
            1: add_vec(0, $urandom, 1);
            2: add_vec($urandom, 0, 1);
            3: add_vec($urandom, $urandom, 1);
            default: add_vec($urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                             $urandom_range(15) != 0);
         endcase
      end
   endtask

   task automatic drain();
      wait (vec_queue.size() == 0 && !req_valid && pixel_queue.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      logic [CFG_W-1:0] radii[5];
      radii = '{16'd2560, 16'd256, 16'd65535, 16'd0, 16'd0};
      radii[3] = 16'($urandom_range(65535, 256));
      radii[4] = 16'($urandom_range(4096, 256));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         snd_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 81 : 0;
         rcv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 15 : 0;
         write_radius(radii[ph]);
         if (ph == 0) begin
            add_vec(0, 0, 1);
            add_vec(32767, -32768, 0);
            add_vec(32767, 32767, 1);
            add_vec(-32768, -32768, 1);
            add_vec(-32768, 32767, 1);
            add_vec(32767, -32768, 1);
            add_vec(0, 100, 1);
            add_vec(0, -100, 1);
            add_vec(100, 0, 1);
            add_vec(-100, 0, 1);
            add_vec(0, -32768, 1);
            add_vec(-32768, 0, 1);
            add_vec(2560, 0, 1);
            add_vec(0, 2561, 1);
            add_vec(5120, 0, 1);
            add_vec(5119, 1, 1);
            add_vec(1, 1, 1);
            add_vec(-1, -1, 1);
            add_vec(1810, -1810, 1);
            add_vec(-1, 1, 0);
         end
         add_random(345);
         drain();
      end
      $display("Covered %0d flow vectors over 5 max_radius settings, incl. extremes,",
               n_vectors);
      $display("zero axes, invalid flags, saturated radii and a long output hold-off.");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: optical_flow_color_coding_core.f
design/ofcc_pkg.sv
design/ofcc_sqrt_cell.sv
design/ofcc_div_cell.sv
design/ofcc_cordic_cell.sv
design/optical_flow_color_coding_core.sv
bench/tb_optical_flow_color_coding_core.sv
